/* hdl/rlkd_pkg.sv */
`timescale 1ns / 1ps

package rlkd_pkg;

    // Keypad geometry and converter resolution
    localparam int BUTTONS    = 4;
    localparam int ADC_BITS   = 12;
    localparam int KEY_W      = $clog2(BUTTONS + 1);
    localparam int IDX_W      = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int NUM_W      = 2 * ADC_BITS;
    localparam int CNT_W      = $clog2(ADC_BITS);
    localparam int LEVELS_W   = 48;
    localparam int DEB_W      = 16;
    localparam int TIME_W     = 32;
    localparam int OUT_KEY_W  = 2;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = LEVELS_W;

    localparam logic [CFG_ADDR_W-1:0] CFG_NORM_EN    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NOMINAL    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_VALID  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_VALID  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACCEPT     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_KEY_LEVELS = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_REST_LEVEL = 3'd7;

    localparam logic [KEY_W-1:0]    KEY_NONE   = KEY_W'(BUTTONS);
    localparam logic [ADC_BITS-1:0] FULL_SCALE = {ADC_BITS{1'b1}};

    // Reported key events
    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_PRESSED  = 2'd1,
        EV_HELD     = 2'd2,
        EV_RELEASED = 2'd3
    } t_event;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CHECK,
        ST_DIVIDE,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic cal;
        logic mul;
        logic check;
        logic div_step;
        logic scan_init;
        logic scan_step;
        logic commit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic action;
        logic div_needed;
        logic div_last;
        logic scan_last;
        logic out_free;
    } t_sts;

    // Absolute difference of two codes
    function automatic logic [ADC_BITS-1:0] f_dist(input logic [ADC_BITS-1:0] a,
                                                   input logic [ADC_BITS-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

/* hdl/resistor_ladder_key_decoder_unit.sv */
`timescale 1ns / 1ps

// Resistor-ladder keypad decoder. Each input transaction carries one ADC reading and a
// millisecond timestamp. A calibrate transaction stores the reading as the measured rest
// level when it lies inside [min_valid_rest, max_valid_rest] and returns nothing. A sample
// transaction optionally rescales the reading by nominal_rest / measured rest (rounded,
// clamped to full scale), picks the nearest ladder level (rest wins ties, higher keys win
// among keys), rejects near-rest and out-of-window readings, debounces the key and returns
// one event: none, pressed, held or released. A rescaled sample runs through the
// 12-step restoring divider and then the 4-step level scan; a reading that passes
// through unscaled or clamps skips the divider, and a calibration skips both. One
// item is in work at a time; the output register lets the next item enter while a
// result waits to be taken.
module resistor_ladder_key_decoder_unit import rlkd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [47:0]           s_axis_tdata,  // [11:0] adc_code, [43:12] now_ms
    input  logic [0:0]            s_axis_tuser,  // [0] action
    // Result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [7:0]            m_axis_tdata,  // [1:0] key_index
    output logic [1:0]            m_axis_tuser   // [1:0] event_kind
);

    t_cmd                 w_cmd;
    t_sts                 w_sts;
    t_event               w_event;
    logic [OUT_KEY_W-1:0] w_key;

    // Sequencer
    rlkd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Scaling, scan and debounce datapath
    rlkd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_action    (s_axis_tuser[0]),
        .i_adc       (s_axis_tdata[ADC_BITS-1:0]),
        .i_now       (s_axis_tdata[ADC_BITS +: TIME_W]),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_event     (w_event),
        .o_key       (w_key)
    );

    assign m_axis_tdata = {{(8 - OUT_KEY_W){1'b0}}, w_key};
    assign m_axis_tuser = w_event;

`ifndef SYNTHESIS
    // A result is never written over one that is still waiting
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result written over a pending result");

    // An accepted transaction is dispatched to calibrate or multiply next
    a_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (w_cmd.cal || w_cmd.mul))
        else $error("accepted transaction not dispatched");

    // Released and none events carry key zero
    a_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (w_event == EV_RELEASED || w_event == EV_NONE)) |-> (w_key == '0))
        else $error("nonzero key on a released or none event");

    // Only one datapath command at a time
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_cmd))
        else $error("overlapping datapath commands");
`endif

endmodule

/* hdl/rlkd_ctrl.sv */
`timescale 1ns / 1ps

module rlkd_ctrl import rlkd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_PREP;
            end
            ST_PREP: begin
                n_state = i_sts.action ? ST_IDLE : ST_CHECK;
            end
            ST_CHECK: begin
                n_state = i_sts.div_needed ? ST_DIVIDE : ST_SCAN_INIT;
            end
            ST_DIVIDE: begin
                if (i_sts.div_last) n_state = ST_SCAN_INIT;
            end
            ST_SCAN_INIT: begin
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (i_sts.scan_last) n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands per state
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_PREP: begin
                o_cmd.cal = i_sts.action;
                o_cmd.mul = !i_sts.action;
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
            end
            ST_DIVIDE: begin
                o_cmd.div_step = 1'b1;
            end
            ST_SCAN_INIT: begin
                o_cmd.scan_init = 1'b1;
            end
            ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            ST_COMMIT: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

/* hdl/rlkd_dp.sv */
`timescale 1ns / 1ps

module rlkd_dp import rlkd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_action,
    input  logic [ADC_BITS-1:0]   i_adc,
    input  logic [TIME_W-1:0]     i_now,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output t_event                o_event,
    output logic [OUT_KEY_W-1:0]  o_key
);

    // Configuration registers
    logic                r_norm_en;
    logic [ADC_BITS-1:0] r_nominal;
    logic [ADC_BITS-1:0] r_min_valid;
    logic [ADC_BITS-1:0] r_max_valid;
    logic [ADC_BITS-1:0] r_accept;
    logic [DEB_W-1:0]    r_debounce;
    logic [LEVELS_W-1:0] r_key_levels;
    logic [ADC_BITS-1:0] r_rest_level;

    // Item and working registers
    logic                r_action;
    logic [ADC_BITS-1:0] r_adc;
    logic [TIME_W-1:0]   r_now;
    logic [NUM_W-1:0]    r_num;
    logic [ADC_BITS-1:0] r_rem;
    logic [ADC_BITS-1:0] r_quo;
    logic [CNT_W-1:0]    r_cnt;
    logic [ADC_BITS-1:0] r_val;
    logic [KEY_W-1:0]    r_best;
    logic [ADC_BITS-1:0] r_best_d;
    logic [IDX_W-1:0]    r_idx;

    // Decoder and debounce state
    logic [ADC_BITS-1:0] r_rest_meas;
    logic [KEY_W-1:0]    r_cand;
    logic [KEY_W-1:0]    r_stable;
    logic [TIME_W-1:0]   r_change;
    logic                r_settling;

    // Output register
    logic                 r_out_valid;
    t_event               r_event;
    logic [OUT_KEY_W-1:0] r_key;

    logic                 w_bypass;
    logic                 w_ovf;
    logic [ADC_BITS:0]    w_div_t;
    logic [ADC_BITS:0]    w_div_sub;
    logic                 w_div_ge;
    logic [ADC_BITS-1:0]  n_rem;
    logic [ADC_BITS-1:0]  n_quo;
    logic [ADC_BITS-1:0]  w_level;
    logic [ADC_BITS-1:0]  w_d_key;
    logic [KEY_W-1:0]     w_nv;
    logic [TIME_W-1:0]    w_elapsed;
    logic                 w_expired;
    logic [KEY_W-1:0]     n_cand;
    logic [KEY_W-1:0]     n_stable;
    logic [TIME_W-1:0]    n_change;
    logic                 n_settling;
    t_event               n_event;
    logic [OUT_KEY_W-1:0] n_key;

    // Scale path: bypass, overflow clamp and one restoring divide step
    assign w_bypass  = !r_norm_en || (r_rest_meas == '0);
    assign w_ovf     = r_num >= {r_rest_meas, {ADC_BITS{1'b0}}};
    assign w_div_t   = {r_rem, r_quo[ADC_BITS-1]};
    assign w_div_ge  = w_div_t >= {1'b0, r_rest_meas};
    assign w_div_sub = w_div_t - {1'b0, r_rest_meas};
    assign n_rem     = w_div_ge ? w_div_sub[ADC_BITS-1:0] : w_div_t[ADC_BITS-1:0];
    assign n_quo     = {r_quo[ADC_BITS-2:0], w_div_ge};

    // Level scan: distance to the key under the index
    assign w_level = r_key_levels[r_idx*ADC_BITS +: ADC_BITS];
    assign w_d_key = f_dist(r_val, w_level);

    // Decoded value of this reading
    always_comb begin
        if (r_val >= r_min_valid || r_best == KEY_NONE || r_best_d > r_accept) begin
            w_nv = KEY_NONE;
        end else begin
            w_nv = r_best;
        end
    end

    assign w_elapsed = r_now - r_change;
    assign w_expired = w_elapsed > TIME_W'(r_debounce);

    // Debounce and event selection
    always_comb begin
        n_cand     = r_cand;
        n_stable   = r_stable;
        n_change   = r_change;
        n_settling = r_settling;
        if (w_nv != r_cand) begin
            n_cand     = w_nv;
            n_change   = r_now;
            n_settling = 1'b1;
            n_event    = (r_stable == KEY_NONE) ? EV_NONE : EV_HELD;
        end else if (r_settling && w_expired) begin
            n_settling = 1'b0;
            n_stable   = r_cand;
            n_event    = (r_cand == KEY_NONE) ? EV_RELEASED : EV_PRESSED;
        end else begin
            n_event    = (r_stable == KEY_NONE) ? EV_NONE : EV_HELD;
        end
        if (n_event == EV_PRESSED || n_event == EV_HELD) begin
            n_key = n_stable[OUT_KEY_W-1:0];
        end else begin
            n_key = '0;
        end
    end

    // Configuration writes and control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm_en    <= 1'b0;
            r_nominal    <= FULL_SCALE;
            r_min_valid  <= FULL_SCALE;
            r_max_valid  <= FULL_SCALE;
            r_accept     <= '0;
            r_debounce   <= DEB_W'(20);
            r_key_levels <= '0;
            r_rest_level <= FULL_SCALE;
            r_rest_meas  <= '0;
            r_cand       <= KEY_NONE;
            r_stable     <= KEY_NONE;
            r_change     <= '0;
            r_settling   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_NORM_EN:    r_norm_en    <= i_cfg_data[0];
                    CFG_NOMINAL:    r_nominal    <= i_cfg_data[ADC_BITS-1:0];
                    CFG_MIN_VALID:  r_min_valid  <= i_cfg_data[ADC_BITS-1:0];
                    CFG_MAX_VALID:  r_max_valid  <= i_cfg_data[ADC_BITS-1:0];
                    CFG_ACCEPT:     r_accept     <= i_cfg_data[ADC_BITS-1:0];
                    CFG_DEBOUNCE:   r_debounce   <= i_cfg_data[DEB_W-1:0];
                    CFG_KEY_LEVELS: r_key_levels <= i_cfg_data[LEVELS_W-1:0];
                    CFG_REST_LEVEL: r_rest_level <= i_cfg_data[ADC_BITS-1:0];
                    default: ;
                endcase
            end
            // Store rest level when the reading lies in the window
            if (i_cmd.cal && r_adc >= r_min_valid && r_adc <= r_max_valid) begin
                r_rest_meas <= r_adc;
            end
            // Advance debounce state together with the result write
            if (i_cmd.commit) begin
                r_cand      <= n_cand;
                r_stable    <= n_stable;
                r_change    <= n_change;
                r_settling  <= n_settling;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_adc    <= i_adc;
            r_now    <= i_now;
        end
        if (i_cmd.mul) begin
            r_num <= NUM_W'(r_adc) * NUM_W'(r_nominal) + NUM_W'(r_rest_meas >> 1);
        end
        if (i_cmd.check) begin
            if (w_bypass) begin
                r_val <= r_adc;
            end else if (w_ovf) begin
                r_val <= FULL_SCALE;
            end else begin
                r_rem <= r_num[NUM_W-1:ADC_BITS];
                r_quo <= r_num[ADC_BITS-1:0];
                r_cnt <= '0;
            end
        end
        if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(ADC_BITS - 1)) r_val <= n_quo;
        end
        if (i_cmd.scan_init) begin
            r_best   <= KEY_NONE;
            r_best_d <= f_dist(r_val, r_rest_level);
            r_idx    <= IDX_W'(BUTTONS - 1);
        end
        // Strict compare: rest and higher keys keep ties
        if (i_cmd.scan_step) begin
            if (w_d_key < r_best_d) begin
                r_best   <= KEY_W'(r_idx);
                r_best_d <= w_d_key;
            end
            r_idx <= r_idx - 1'b1;
        end
        if (i_cmd.commit) begin
            r_event <= n_event;
            r_key   <= n_key;
        end
    end

    assign o_sts.action     = r_action;
    assign o_sts.div_needed = !w_bypass && !w_ovf;
    assign o_sts.div_last   = r_cnt == CNT_W'(ADC_BITS - 1);
    assign o_sts.scan_last  = r_idx == '0;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_event     = r_event;
    assign o_key       = r_key;

endmodule

/* verif/resistor_ladder_key_decoder_unit_tb.sv */
`timescale 1ns / 1ps

module resistor_ladder_key_decoder_unit_tb;
    import rlkd_pkg::*;

    localparam int SETTLE_CYCLES = 48;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_SAMPLES = 106;
    localparam int MAX_REPORTS   = 40;

    localparam logic ACT_SAMPLE    = 1'b0;
    localparam logic ACT_CALIBRATE = 1'b1;

    typedef enum {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic                action;
        logic [ADC_BITS-1:0] adc;
        logic [TIME_W-1:0]   now;
    } ladder_item_t;

    typedef struct {
        t_event               kind;
        logic [OUT_KEY_W-1:0] key;
    } key_event_t;

    typedef struct {
        logic                norm_en;
        logic [ADC_BITS-1:0] nominal;
        logic [ADC_BITS-1:0] min_valid;
        logic [ADC_BITS-1:0] max_valid;
        logic [ADC_BITS-1:0] accept;
        logic [DEB_W-1:0]    debounce;
        logic [LEVELS_W-1:0] levels;
        logic [ADC_BITS-1:0] rest_level;
    } ladder_cfg_t;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [47:0]           s_axis_tdata  = '0;  // [11:0] adc_code, [43:12] now_ms
    logic [0:0]            s_axis_tuser  = '0;  // [0] action
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;        // [1:0] key_index
    logic [1:0]            m_axis_tuser;        // [1:0] event_kind

    resistor_ladder_key_decoder_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // Register copies kept by the predictor
    logic                cfg_norm_en;
    logic [ADC_BITS-1:0] cfg_nominal;
    logic [ADC_BITS-1:0] cfg_min_valid;
    logic [ADC_BITS-1:0] cfg_max_valid;
    logic [ADC_BITS-1:0] cfg_accept;
    logic [DEB_W-1:0]    cfg_debounce;
    logic [LEVELS_W-1:0] cfg_levels;
    logic [ADC_BITS-1:0] cfg_rest_level;

    // Debounce state kept by the predictor
    logic [ADC_BITS-1:0] rest_cal;
    logic [KEY_W-1:0]    cand_key;
    logic [KEY_W-1:0]    stable_key;
    logic [TIME_W-1:0]   change_ms;
    logic                settling;

    ladder_item_t item_q[$];
    key_event_t   pending_events[$];
    ladder_item_t drv_item;
    logic         in_taken = 1'b0;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           quiet_cycles = 0;
    int           error_count  = 0;
    int           queued_samples = 0;
    int           n_samples = 0;
    int           n_cal = 0;
    int           n_cal_taken = 0;
    int           n_settings = 0;
    int           ev_count[4] = '{0, 0, 0, 0};

    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic [ADC_BITS-1:0] clamp_code(input int v);
        if (v < 0) return '0;
        if (v > int'(FULL_SCALE)) return FULL_SCALE;
        return v[ADC_BITS-1:0];
    endfunction

    function automatic logic [ADC_BITS-1:0] near(input int center, input int spread);
        return clamp_code(center + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    function automatic logic [31:0] code_gap(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Rescale, then pick the nearest ladder level; rest wins ties, higher keys win among keys
    function automatic logic [KEY_W-1:0] ladder_decode(input logic [ADC_BITS-1:0] adc);
        logic [31:0]      v;
        logic [31:0]      best_d;
        logic [31:0]      d;
        logic [KEY_W-1:0] best;
        v = 32'(adc);
        if (cfg_norm_en && rest_cal != '0) begin
            v = (32'(adc) * 32'(cfg_nominal) + 32'(rest_cal) / 2) / 32'(rest_cal);
            if (v > 32'(FULL_SCALE)) v = 32'(FULL_SCALE);
        end
        if (v >= 32'(cfg_min_valid)) return KEY_NONE;
        best   = KEY_NONE;
        best_d = code_gap(v, 32'(cfg_rest_level));
        for (int i = BUTTONS - 1; i >= 0; i--) begin
            d = code_gap(v, 32'(cfg_levels[ADC_BITS*i +: ADC_BITS]));
            if (d < best_d) begin
                best   = KEY_W'(i);
                best_d = d;
            end
        end
        if (best == KEY_NONE || best_d > 32'(cfg_accept)) return KEY_NONE;
        return best;
    endfunction

    task automatic reset_model();
        cfg_norm_en    = 1'b0;
        cfg_nominal    = FULL_SCALE;
        cfg_min_valid  = FULL_SCALE;
        cfg_max_valid  = FULL_SCALE;
        cfg_accept     = '0;
        cfg_debounce   = DEB_W'(20);
        cfg_levels     = '0;
        cfg_rest_level = FULL_SCALE;
        rest_cal       = '0;
        cand_key       = KEY_NONE;
        stable_key     = KEY_NONE;
        change_ms      = '0;
        settling       = 1'b0;
    endtask

    // Advance the debounce state by one accepted sample and queue its event; a calibration only updates the rest level
    task automatic predict_key_event(input logic act, input logic [ADC_BITS-1:0] adc,
                                     input logic [TIME_W-1:0] now);
        logic [KEY_W-1:0] nv;
        key_event_t       ev;
        if (act == ACT_CALIBRATE) begin
            n_cal++;
            if (adc >= cfg_min_valid && adc <= cfg_max_valid) begin
                rest_cal = adc;
                n_cal_taken++;
            end
            return;
        end
        n_samples++;
        nv = ladder_decode(adc);
        if (nv != cand_key) begin
            cand_key  = nv;
            change_ms = now;
            settling  = 1'b1;
            ev.kind   = (stable_key == KEY_NONE) ? EV_NONE : EV_HELD;
        end else if (settling && (now - change_ms) > 32'(cfg_debounce)) begin
            settling   = 1'b0;
            stable_key = cand_key;
            ev.kind    = (stable_key == KEY_NONE) ? EV_RELEASED : EV_PRESSED;
        end else begin
            ev.kind = (stable_key == KEY_NONE) ? EV_NONE : EV_HELD;
        end
        ev.key = (ev.kind == EV_PRESSED || ev.kind == EV_HELD) ?
                 stable_key[OUT_KEY_W-1:0] : '0;
        ev_count[ev.kind]++;
        pending_events.push_back(ev);
    endtask

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS) $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        case (addr)
            CFG_NORM_EN:    cfg_norm_en    = data[0];
            CFG_NOMINAL:    cfg_nominal    = data[ADC_BITS-1:0];
            CFG_MIN_VALID:  cfg_min_valid  = data[ADC_BITS-1:0];
            CFG_MAX_VALID:  cfg_max_valid  = data[ADC_BITS-1:0];
            CFG_ACCEPT:     cfg_accept     = data[ADC_BITS-1:0];
            CFG_DEBOUNCE:   cfg_debounce   = data[DEB_W-1:0];
            CFG_KEY_LEVELS: cfg_levels     = data[LEVELS_W-1:0];
            CFG_REST_LEVEL: cfg_rest_level = data[ADC_BITS-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_config(input ladder_cfg_t c);
        write_reg(CFG_NORM_EN,    CFG_DATA_W'(c.norm_en));
        write_reg(CFG_NOMINAL,    CFG_DATA_W'(c.nominal));
        write_reg(CFG_MIN_VALID,  CFG_DATA_W'(c.min_valid));
        write_reg(CFG_MAX_VALID,  CFG_DATA_W'(c.max_valid));
        write_reg(CFG_ACCEPT,     CFG_DATA_W'(c.accept));
        write_reg(CFG_DEBOUNCE,   CFG_DATA_W'(c.debounce));
        write_reg(CFG_KEY_LEVELS, CFG_DATA_W'(c.levels));
        write_reg(CFG_REST_LEVEL, CFG_DATA_W'(c.rest_level));
        n_settings++;
    endtask

    task automatic set_idling(input idle_mode_t m);
        send_idle_pct  = (m == IDLE_SENDER)   ? 82 : (m == IDLE_BOTH) ? 33 : 0;
        recv_stall_pct = (m == IDLE_RECEIVER) ? 82 : (m == IDLE_BOTH) ? 33 : 0;
    endtask

    task automatic push_item(input logic act, input logic [ADC_BITS-1:0] adc,
                             input logic [TIME_W-1:0] now);
        ladder_item_t it;
        it.action = act;
        it.adc    = adc;
        it.now    = now;
        item_q.push_back(it);
        if (act == ACT_SAMPLE) queued_samples++;
    endtask

    // Hold until every item is taken and every event is back, then let the block settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (item_q.size() != 0 || s_axis_tvalid || pending_events.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Driver: present the next item once the current transaction is taken
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || in_taken) begin
            if (item_q.size() != 0 && !chance(send_idle_pct)) begin
                drv_item = item_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {4'd0, drv_item.now, drv_item.adc};
                s_axis_tuser  <= drv_item.action;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= !chance(recv_stall_pct);
    end

    // Monitor: predict on input transactions, check output transactions in order
    always @(posedge i_clk) begin
        key_event_t ev;
        in_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            predict_key_event(s_axis_tuser[0], s_axis_tdata[ADC_BITS-1:0],
                              s_axis_tdata[ADC_BITS +: TIME_W]);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_events.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: kind %0d data %0h",
                                          m_axis_tuser, m_axis_tdata));
            end else begin
                ev = pending_events.pop_front();
                if (m_axis_tuser !== ev.kind)
                    report_mismatch($sformatf("event_kind %0d, expected %s",
                                              m_axis_tuser, ev.kind.name()));
                if (m_axis_tdata !== 8'(ev.key))
                    report_mismatch($sformatf("tdata %0h, expected key_index %0d",
                                              m_axis_tdata, ev.key));
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        ladder_cfg_t       c;
        logic [TIME_W-1:0] t;
        int                k;
        int                n;
        int                cat;
        int                cal_center;
        int                base;

        reset_model();
        set_idling(IDLE_NONE);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: all keys sit at code 0, so key 3 wins the tie
        push_item(ACT_CALIBRATE, FULL_SCALE, 32'd0);
        push_item(ACT_SAMPLE, 12'd0, 32'd0);
        push_item(ACT_SAMPLE, 12'd0, 32'd21);
        push_item(ACT_SAMPLE, FULL_SCALE, 32'd30);
        push_item(ACT_SAMPLE, FULL_SCALE, 32'd51);
        wait_drained();

        // Key ties, rest ties, rejection, calibration window edges, clamp, timer wrap
        c.norm_en    = 1'b1;
        c.nominal    = FULL_SCALE;
        c.min_valid  = 12'd3000;
        c.max_valid  = 12'd4000;
        c.accept     = 12'd100;
        c.debounce   = '0;
        c.levels     = {12'd2500, 12'd1500, 12'd1500, 12'd500};
        c.rest_level = 12'd2000;
        apply_config(c);
        push_item(ACT_CALIBRATE, 12'd2999, 32'd0);
        push_item(ACT_CALIBRATE, 12'd4001, 32'd0);
        push_item(ACT_SAMPLE, 12'd1500, 32'd1);
        push_item(ACT_SAMPLE, 12'd1500, 32'd2);
        push_item(ACT_SAMPLE, 12'd1750, 32'd3);
        push_item(ACT_SAMPLE, 12'd1750, 32'd4);
        push_item(ACT_SAMPLE, 12'd2700, 32'd5);
        push_item(ACT_CALIBRATE, 12'd3000, 32'd6);
        push_item(ACT_SAMPLE, 12'd2200, 32'd7);
        push_item(ACT_SAMPLE, 12'd4000, 32'd8);
        push_item(ACT_CALIBRATE, 12'd4000, 32'd9);
        push_item(ACT_SAMPLE, 12'd2442, 32'hFFFF_FFFE);
        push_item(ACT_SAMPLE, 12'd2442, 32'h0000_0003);
        wait_drained();

        // Register extremes: longest debounce, widest acceptance, empty calibration window
        c.norm_en    = 1'b0;
        c.nominal    = '0;
        c.min_valid  = FULL_SCALE;
        c.max_valid  = '0;
        c.accept     = FULL_SCALE;
        c.debounce   = '1;
        c.levels     = '1;
        c.rest_level = '0;
        apply_config(c);
        push_item(ACT_CALIBRATE, 12'd0, 32'd0);
        push_item(ACT_SAMPLE, 12'd0, 32'd0);
        push_item(ACT_SAMPLE, 12'd4094, 32'd10);
        push_item(ACT_SAMPLE, 12'd4094, 32'd65545);
        push_item(ACT_SAMPLE, 12'd4094, 32'd65546);
        push_item(ACT_SAMPLE, 12'd2048, 32'd65547);
        push_item(ACT_SAMPLE, 12'd2047, 32'd65548);
        wait_drained();

        // Random phases: mostly press and release sequences, some calibrations and noise
        t = 32'd0;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            c.norm_en    = (p % 2 == 1);
            c.min_valid  = 12'($urandom_range(3000, 3400));
            c.max_valid  = 12'($urandom_range(c.min_valid, 4095));
            cal_center   = $urandom_range(c.min_valid, c.max_valid);
            c.nominal    = near(cal_center, 40);
            c.rest_level = 12'($urandom_range(3500, 4095));
            c.accept     = 12'($urandom_range(30, 350));
            c.debounce   = 16'($urandom_range(0, 40));
            for (int i = 0; i < BUTTONS; i++)
                c.levels[ADC_BITS*i +: ADC_BITS] = 12'(i * 700 + 150 + $urandom_range(0, 400));
            case (p % 8)
                1: c.debounce = '1;
                2: begin
                    c.max_valid  = FULL_SCALE;
                    c.rest_level = FULL_SCALE;
                end
                3: c.accept = FULL_SCALE;
                4: c.levels[2*ADC_BITS +: ADC_BITS] = c.levels[ADC_BITS +: ADC_BITS];
                5: c.debounce = '0;
                6: begin
                    c.norm_en = 1'b1;
                    c.nominal = '0;
                end
                7: c.min_valid = '0;
                default: ;
            endcase
            apply_config(c);
            set_idling(idle_mode_t'(p % 4));
            if (p % 4 == 2) t = 32'hFFFF_FFFF - $urandom_range(0, 300);
            push_item(ACT_CALIBRATE, near(cal_center, 20), t);
            base = queued_samples;
            while (queued_samples - base < PHASE_SAMPLES) begin
                cat = $urandom_range(0, 99);
                if (cat < 10) begin
                    // noise: any action, code and timestamp
                    t = $urandom;
                    push_item(1'($urandom_range(0, 1)), 12'($urandom), t);
                end else if (cat < 20) begin
                    push_item(ACT_CALIBRATE,
                              ($urandom_range(0, 2) != 0) ? near(cal_center, 40) : 12'($urandom),
                              t);
                end else begin
                    // press one key, with some bounce, then let go
                    k = $urandom_range(0, BUTTONS - 1);
                    n = $urandom_range(3, 7);
                    repeat (n) begin
                        t += $urandom_range(0, c.debounce / 2 + 8);
                        push_item(ACT_SAMPLE,
                                  chance(15) ? 12'($urandom) :
                                  near(c.levels[ADC_BITS*k +: ADC_BITS], c.accept + 20), t);
                    end
                    n = $urandom_range(2, 5);
                    repeat (n) begin
                        t += $urandom_range(0, c.debounce / 2 + 8);
                        push_item(ACT_SAMPLE, 12'($urandom_range(c.min_valid, 4095)), t);
                    end
                end
            end
            wait_drained();
        end

        $display("Run covered %0d samples and %0d calibrations (%0d taken) over %0d settings",
                 n_samples, n_cal, n_cal_taken, n_settings);
        $display("Events: %0d none, %0d pressed, %0d held, %0d released; %0d mismatches",
                 ev_count[EV_NONE], ev_count[EV_PRESSED], ev_count[EV_HELD],
                 ev_count[EV_RELEASED], error_count);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
